// ----- hdl/pba_pkg.sv -----
package pba_pkg;

  localparam int MODE_W  = 2;
  localparam int PAGE_W  = 13;
  localparam int COUNT_W = 14;

  // Largest free count that the result field can carry; larger totals saturate.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Fixed-point scale of the reciprocal used to split a page number into
  // word index and bit index.
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE  = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_COUNT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_CHK,
    ST_RMW,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/page_bitmap_allocator.sv -----
// Channel  Direction  Handshake            Fields
// in       input      in_valid / in_stall   in_mode, in_page_number
// out      output     out_valid / out_stall out_page_out, out_found, out_free_count
//
// Free and mark split the page number into word and bit with a reciprocal multiply
// in ST_DIV, ST_REM and ST_CHK, the last of which reads the map; ST_RMW writes the
// map word and ST_FIN loads the result.
// Allocate and count stream the map memory one word per cycle through its single
// read port; allocate stops at the first word with a free page. One request is in
// flight at a time.
// After reset the map is cleared one word per cycle, with in_stall high. A finished
// word waits in the output register, so a new request can be taken while out_stall
// holds the previous result.
module page_bitmap_allocator #(
  parameter int MAP_WORDS = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pba_pkg::MODE_W-1:0]   in_mode,
  input  logic [pba_pkg::PAGE_W-1:0]   in_page_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pba_pkg::PAGE_W-1:0]   out_page_out,
  output logic                          out_found,
  output logic [pba_pkg::COUNT_W-1:0]  out_free_count
);

  import pba_pkg::*;

  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int AC    = $clog2(MAP_WORDS + 1);
  localparam int BW    = $clog2(WORD_BITS);
  localparam int PW    = $clog2(WORD_BITS + 1);
  localparam int CW    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int RECIP = (1 << RECIP_SHIFT) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int QW    = PAGE_W + RW - RECIP_SHIFT;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic [BW:0]         rem_r, rem_nxt;
  logic [AW-1:0]       word_r, word_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [AC-1:0]       ra_r, ra_nxt;
  logic                pv_r, pv_nxt;
  logic [AW-1:0]       pa_r, pa_nxt;
  logic [PW-1:0]       pop_r, pop_nxt;
  logic                popv_r, popv_nxt;
  logic [CW-1:0]       acc_r, acc_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_w_r, hit_w_nxt;
  logic [BW-1:0]       hit_b_r, hit_b_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;
  logic                out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [PW-1:0]       wu_pop;
  logic [BW-1:0]       wu_idx;
  logic                wu_any;

  logic [PAGE_W+RW-1:0] prod;
  logic [PAGE_W:0]      rem_full;
  logic [QW:0]          qc;
  logic [BW-1:0]        bc;
  logic [WORD_BITS-1:0] bit_mask;
  logic [31:0]          pg_full;
  logic [COUNT_W-1:0]   count_sat;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pba_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .word    (ram_rdata),
    .pop     (wu_pop),
    .low_idx (wu_idx),
    .any     (wu_any)
  );

  assign prod     = (PAGE_W+RW)'(page_r) * (PAGE_W+RW)'(RECIP);
  assign rem_full = {1'b0, page_r} - ((PAGE_W+1)'(q_r) * (PAGE_W+1)'(WORD_BITS));
  assign bit_mask = WORD_BITS'(1) << bit_r;
  assign pg_full  = 32'(hit_w_r) * 32'(WORD_BITS) + 32'(hit_b_r);
  assign count_sat = (32'(acc_r) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(acc_r);

  // The reciprocal quotient can come out one low; a single compare fixes it.
  always_comb begin
    if (rem_r >= (BW+1)'(WORD_BITS)) begin
      qc = (QW+1)'(q_r) + (QW+1)'(1);
      bc = BW'(rem_r - (BW+1)'(WORD_BITS));
    end else begin
      qc = (QW+1)'(q_r);
      bc = BW'(rem_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    page_nxt      = page_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    ra_nxt        = ra_r;
    pv_nxt        = pv_r;
    pa_nxt        = pa_r;
    pop_nxt       = pop_r;
    popv_nxt      = popv_r;
    acc_nxt       = acc_r;
    hit_nxt       = hit_r;
    hit_w_nxt     = hit_w_r;
    hit_b_nxt     = hit_b_r;
    out_valid_nxt = out_valid_r;
    out_page_nxt  = out_page_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = word_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ra_r[AW-1:0];
        ram_wdata = '0;
        ra_nxt    = ra_r + AC'(1);
        if (ra_r == AC'(MAP_WORDS - 1)) begin
          ra_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = mode_t'(in_mode);
          page_nxt = in_page_number;
          ra_nxt   = '0;
          pv_nxt   = 1'b0;
          popv_nxt = 1'b0;
          acc_nxt  = '0;
          hit_nxt  = 1'b0;
          case (mode_t'(in_mode))
            MODE_FREE, MODE_MARK: state_nxt = ST_DIV;
            default:              state_nxt = ST_SCAN;
          endcase
        end
      end

      ST_DIV: begin
        q_nxt     = prod[RECIP_SHIFT +: QW];
        state_nxt = ST_REM;
      end

      ST_REM: begin
        rem_nxt   = rem_full[BW:0];
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        word_nxt  = AW'(qc);
        bit_nxt   = bc;
        ram_raddr = AW'(qc);
        // A page past the end of the map leaves the map alone.
        if (32'(qc) < 32'(MAP_WORDS)) begin
          state_nxt = ST_RMW;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = word_r;
        ram_wdata = (mode_r == MODE_FREE) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        state_nxt = ST_FIN;
      end

      ST_SCAN: begin
        if (mode_r == MODE_ALLOC && pv_r && wu_any) begin
          ram_we    = 1'b1;
          ram_waddr = pa_r;
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << wu_idx);
          hit_nxt   = 1'b1;
          hit_w_nxt = pa_r;
          hit_b_nxt = wu_idx;
          pv_nxt    = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          // Reads are issued one word ahead of the data coming back, and the
          // bit count of a word is registered in pop_r before it is added to acc_r.
          pop_nxt  = wu_pop;
          popv_nxt = pv_r;
          if (popv_r) begin
            acc_nxt = acc_r + CW'(pop_r);
          end
          if (ra_r != AC'(MAP_WORDS)) begin
            ram_raddr = ra_r[AW-1:0];
            pa_nxt    = ra_r[AW-1:0];
            pv_nxt    = 1'b1;
            ra_nxt    = ra_r + AC'(1);
          end else begin
            pv_nxt = 1'b0;
          end
          if (ra_r == AC'(MAP_WORDS) && !pv_r && !popv_r) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = hit_r ? pg_full[PAGE_W-1:0] : '0;
          out_found_nxt = hit_r;
          out_count_nxt = (mode_r == MODE_COUNT) ? count_sat : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ra_r        <= '0;
      pv_r        <= 1'b0;
      popv_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ra_r        <= ra_nxt;
      pv_r        <= pv_nxt;
      popv_r      <= popv_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    page_r      <= page_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    word_r      <= word_nxt;
    bit_r       <= bit_nxt;
    pa_r        <= pa_nxt;
    pop_r       <= pop_nxt;
    acc_r       <= acc_nxt;
    hit_w_r     <= hit_w_nxt;
    hit_b_r     <= hit_b_nxt;
    out_page_r  <= out_page_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_page_out   = out_page_r;
  assign out_found      = out_found_r;
  assign out_free_count = out_count_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("map written while idle");

  a_hit_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && hit_r) |-> (mode_r == MODE_ALLOC))
    else $error("page granted outside allocate");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ra_r <= AC'(MAP_WORDS)))
    else $error("scan address past end of map");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("result dropped while output blocked");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE && state_r != ST_CLEAR))
    else $error("accepted word did not start work");

endmodule

// ----- hdl/pba_ram.sv -----
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pba_word_unit.sv -----
module pba_word_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]            word,
  output logic [$clog2(WORD_BITS+1)-1:0] pop,
  output logic [$clog2(WORD_BITS)-1:0]   low_idx,
  output logic                            any
);

  localparam int NCH = (WORD_BITS + 7) / 8;
  localparam int PW  = $clog2(WORD_BITS + 1);
  localparam int BW  = $clog2(WORD_BITS);

  logic [NCH*8-1:0] pad;
  logic [3:0]       ccnt [NCH];
  logic [NCH-1:0]   cany;
  logic [PW-1:0]    total;
  logic [2:0]       lo_c;
  logic [2:0]       lo_b;
  logic [7:0]       lo_chunk;
  logic [5:0]       idx;

  // Bits are counted and searched a byte at a time, then across bytes,
  // which keeps both chains short.
  always_comb begin
    pad = (NCH*8)'(word);
    for (int c = 0; c < NCH; c++) begin
      ccnt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        ccnt[c] = ccnt[c] + 4'(pad[c*8+b]);
      end
      cany[c] = |pad[c*8 +: 8];
    end

    total = '0;
    for (int c = 0; c < NCH; c++) begin
      total = total + PW'(ccnt[c]);
    end

    lo_c = '0;
    for (int c = NCH - 1; c >= 0; c--) begin
      if (cany[c]) begin
        lo_c = 3'(c);
      end
    end

    lo_chunk = pad[lo_c*8 +: 8];
    lo_b = '0;
    for (int b = 7; b >= 0; b--) begin
      if (lo_chunk[b]) begin
        lo_b = 3'(b);
      end
    end
    idx = {lo_c, lo_b};
  end

  assign pop     = total;
  assign low_idx = idx[BW-1:0];
  assign any     = |word;

endmodule
